>>> rtl/rte_pkg.sv
// Package for the radar target emulator: phase codes, register indexes,
// fixed-point widths and the launch speed table.
// Used by radar_target_emulator and rte_checker; depends on nothing else.
package rte_pkg;

   // Number of automatic launch speed slots in use, and position fraction bits.
   localparam int unsigned SPEED_SLOTS = 4;
   localparam int unsigned FRAC_BITS   = 4;

   // Field widths of the streams.
   localparam int unsigned SPEED_W  = 8;
   localparam int unsigned MM_W     = 16;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned PICK_W   = 10;
   localparam int unsigned OBJ_Y_W  = 17;
   localparam int unsigned PHASE_W  = 3;
   localparam int unsigned REQ_DATA_W = 72;
   localparam int unsigned RSP_DATA_W = 48;

   // Configuration port.
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_RADAR_RANGE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_APPROACH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DETECT_ZONE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_EXIT_HOLD    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LAUNCH_IVAL  = 3'd4;

   // Operation codes carried in the request tuser.
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_ARRIVAL = 1'b1;

   // Phase codes.
   localparam logic [PHASE_W-1:0] PH_WAIT  = 3'd0;
   localparam logic [PHASE_W-1:0] PH_ENTER = 3'd1;
   localparam logic [PHASE_W-1:0] PH_VIEW  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_DET   = 3'd3;
   localparam logic [PHASE_W-1:0] PH_LEFT  = 3'd4;

   // Position in millimetres with FRAC_BITS fraction bits.
   localparam int unsigned POS_W = OBJ_Y_W + FRAC_BITS;

   // Step per tick is floor(speed * 250 * 2^FRAC_BITS / 36). It is formed as
   // speed times a rounded-up reciprocal; with STEP_SHIFT of 16 the error stays
   // below 1/36 for every 8-bit speed, so the floor is exact.
   localparam int unsigned      STEP_SHIFT = 16;
   localparam longint unsigned  STEP_MULT  = 64'd250 << FRAC_BITS;
   localparam longint unsigned  STEP_RECIP = ((STEP_MULT << STEP_SHIFT) + 64'd35) / 64'd36;
   localparam int unsigned      RECIP_W    = $clog2(STEP_RECIP + 64'd1);
   localparam int unsigned      PROD_W     = SPEED_W + RECIP_W;
   localparam int unsigned      STEP_W     = PROD_W - STEP_SHIFT;

   // Speed slot counter.
   localparam int unsigned SLOT_W = (SPEED_SLOTS > 1) ? $clog2(SPEED_SLOTS) : 1;

   // Launch speeds for automatic launches, km/h.
   localparam logic [SPEED_W-1:0] LAUNCH_SPEED [4] = '{8'd30, 8'd50, 8'd80, 8'd50};

   // Lateral offset drawn from the random pick: (pick mod 769) - 384.
   localparam logic [PICK_W-1:0] PICK_MOD    = 10'd769;
   localparam logic [MM_W-1:0]   PICK_CENTRE = 16'd384;

   // Result tdata bit positions, lowest first.
   localparam int unsigned RSP_VIS_LSB   = 0;
   localparam int unsigned RSP_X_LSB     = 1;
   localparam int unsigned RSP_Y_LSB     = 17;
   localparam int unsigned RSP_PULSE_LSB = 34;
   localparam int unsigned RSP_SPEED_LSB = 35;
   localparam int unsigned RSP_PHASE_LSB = 43;

endpackage

>>> rtl/radar_target_emulator.sv
// Radar target emulator top level: input register, phase update and result register.
// Depends on rte_pkg.
//
// Emulates one vehicle driving towards a radar through the phases waiting,
// entering, in view, detected and left. Each request transfer (tuser 0 for an
// update tick, 1 for an arrival notice) yields exactly one response transfer
// carrying visibility, position, a detection pulse with speed, and the phase.
// An item passes through the input register and then the result register;
// the phase update between them is combinational logic,
// so a new request is taken every cycle while the response side keeps up.
// Configuration writes are always accepted and take effect at once; they
// should be made only while no request is in flight.
module radar_target_emulator
   import rte_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request: tdata = now_ms[31:0], master_active[32], timers_idle[33],
   // arrival_speed_kmh[41:34], arrival_x_mm[57:42], random_pick[67:58], zeros
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // tuser = operation[0]
   input  logic                  req_tuser,
   // Response: tdata = visible[0], obj_x_mm[16:1], obj_y_mm[33:17],
   // detect_pulse[34], detect_speed_kmh[42:35], phase[45:43], zeros
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // Configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // Configuration registers.
   logic [MM_W-1:0]   range_ff, extra_ff, zone_ff;
   logic [TIME_W-1:0] hold_ff, ival_ff;

   // Input register.
   logic                  in_valid_ff;
   logic [REQ_DATA_W-1:0] in_data_ff;
   logic                  in_op_ff;

   // Emulator state.
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic [MM_W-1:0]    x_ff, x_in;
   logic [TIME_W-1:0]  start_ff, start_in;
   logic               sent_ff, sent_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;

   // Result register.
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Unpacked request fields.
   logic [TIME_W-1:0]  now;
   logic               master;
   logic               idle;
   logic [SPEED_W-1:0] a_speed;
   logic [MM_W-1:0]    a_x;
   logic [PICK_W-1:0]  pick;

   // Working values.
   logic               advance;
   logic [POS_W-1:0]   range_q, zone_q, launch_pos, moved, step_ext;
   logic [PICK_W-1:0]  pick_red;
   logic [MM_W-1:0]    rand_x;
   logic [TIME_W-1:0]  wait_start;
   logic [3:0]         slot_ext;
   logic               do_launch;
   logic [SPEED_W-1:0] launch_speed;
   logic [MM_W-1:0]    launch_x;
   logic [PROD_W-1:0]  step_prod;
   logic               pulse;
   logic               visible;

   assign now     = in_data_ff[31:0];
   assign master  = in_data_ff[32];
   assign idle    = in_data_ff[33];
   assign a_speed = in_data_ff[41:34];
   assign a_x     = in_data_ff[57:42];
   assign pick    = in_data_ff[67:58];

   // Handshakes: the input register moves on whenever the result register frees.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= 16'd10000;
         extra_ff <= 16'd0;
         zone_ff  <= 16'd5000;
         hold_ff  <= 32'd5000;
         ival_ff  <= 32'd8000;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_RADAR_RANGE: range_ff <= csr_data[MM_W-1:0];
            REG_APPROACH:    extra_ff <= csr_data[MM_W-1:0];
            REG_DETECT_ZONE: zone_ff  <= csr_data[MM_W-1:0];
            REG_EXIT_HOLD:   hold_ff  <= csr_data;
            REG_LAUNCH_IVAL: ival_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_op_ff   <= req_tuser;
      end
   end

   // Shared values: thresholds in fixed point, launch position, moved position, random offset and wait start.
   always_comb begin
      range_q    = POS_W'(range_ff) << FRAC_BITS;
      zone_q     = POS_W'(zone_ff) << FRAC_BITS;
      launch_pos = POS_W'(OBJ_Y_W'(range_ff) + OBJ_Y_W'(extra_ff)) << FRAC_BITS;
      step_ext   = POS_W'(step_ff);
      moved      = (pos_ff > step_ext) ? pos_ff - step_ext : '0;
      pick_red   = (pick >= PICK_MOD) ? pick - PICK_MOD : pick;
      rand_x     = MM_W'(pick_red) - PICK_CENTRE;
      wait_start = (start_ff == '0) ? now : start_ff;
      slot_ext   = 4'(slot_ff);
   end

   // Phase update for the item in the input register.
   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      step_in      = step_ff;
      speed_in     = speed_ff;
      x_in         = x_ff;
      start_in     = start_ff;
      sent_in      = sent_ff;
      slot_in      = slot_ff;
      pulse        = 1'b0;
      do_launch    = 1'b0;
      launch_speed = a_speed;
      launch_x     = a_x;

      if (in_op_ff == OP_ARRIVAL) begin
         if (phase_ff == PH_WAIT || phase_ff == PH_LEFT || phase_ff == PH_ENTER) begin
            do_launch = 1'b1;
         end
      end else begin
         case (phase_ff)
            PH_WAIT: begin
               if (master) begin
                  start_in = wait_start;
                  if (now - wait_start >= ival_ff) begin
                     do_launch    = 1'b1;
                     launch_speed = LAUNCH_SPEED[slot_ext[1:0]];
                     launch_x     = '0;
                     slot_in      = (32'(slot_ff) == SPEED_SLOTS - 1) ? '0 : slot_ff + 1'b1;
                  end
               end
            end
            PH_ENTER: begin
               if (moved <= range_q) begin
                  pos_in   = range_q;
                  phase_in = PH_VIEW;
               end else begin
                  pos_in = moved;
               end
            end
            PH_VIEW, PH_DET: begin
               pos_in = moved;
               if (!sent_ff && moved <= zone_q) begin
                  phase_in = PH_DET;
                  sent_in  = 1'b1;
                  pulse    = 1'b1;
               end
               if (moved == '0) begin
                  phase_in = PH_LEFT;
                  start_in = now;
               end
            end
            PH_LEFT: begin
               if (idle && (now - start_ff >= hold_ff)) begin
                  phase_in = PH_WAIT;
                  start_in = now;
               end
            end
            default: ;
         endcase
      end

      // Launch: step from the speed by reciprocal multiplication.
      step_prod = PROD_W'(launch_speed) * PROD_W'(STEP_RECIP);
      if (do_launch) begin
         x_in     = (launch_x == '0) ? rand_x : launch_x;
         pos_in   = launch_pos;
         speed_in = launch_speed;
         step_in  = STEP_W'(step_prod >> STEP_SHIFT);
         phase_in = PH_ENTER;
         sent_in  = 1'b0;
         start_in = now;
      end
   end

   // Result fields from the updated state.
   always_comb begin
      visible = (phase_in == PH_VIEW || phase_in == PH_DET) &&
                pos_in != '0 && pos_in <= range_q;
      rsp_data_in = '0;
      rsp_data_in[RSP_VIS_LSB]                 = visible;
      rsp_data_in[RSP_X_LSB +: MM_W]           = visible ? x_in : '0;
      rsp_data_in[RSP_Y_LSB +: OBJ_Y_W]        =
         visible ? OBJ_Y_W'(pos_in >> FRAC_BITS) : '0;
      rsp_data_in[RSP_PULSE_LSB]               = pulse;
      rsp_data_in[RSP_SPEED_LSB +: SPEED_W]    = pulse ? speed_in : '0;
      rsp_data_in[RSP_PHASE_LSB +: PHASE_W]    = phase_in;
   end

   // State and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         pos_ff       <= '0;
         step_ff      <= '0;
         speed_ff     <= '0;
         x_ff         <= '0;
         start_ff     <= '0;
         sent_ff      <= 1'b0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            step_ff  <= step_in;
            speed_ff <= speed_in;
            x_ff     <= x_in;
            start_ff <= start_in;
            sent_ff  <= sent_in;
            slot_ff  <= slot_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

>>> rtl/rte_checker.sv
// Port-level checks for the radar target emulator, bound to the top level.
// Depends on rte_pkg and radar_target_emulator.
module rte_checker
   import rte_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [PHASE_W-1:0] rsp_phase;
   assign rsp_phase = rsp_tdata[RSP_PHASE_LSB +: PHASE_W];

   // A stalled response transfer keeps its data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // A detection pulse is given in the detected phase, or in the left phase when the
   // car reaches zero on the very tick that first enters the detection zone.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_PULSE_LSB] |-> rsp_phase == PH_DET || rsp_phase == PH_LEFT)
      else $error("detection pulse outside the detected or left phase");

   // Visibility needs the in-view or detected phase.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_VIS_LSB] |-> rsp_phase == PH_VIEW || rsp_phase == PH_DET)
      else $error("visible outside the view phases");

   // A hidden vehicle reports no position, and no pulse means no speed.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_VIS_LSB] || rsp_tdata[RSP_PULSE_LSB - 1:RSP_X_LSB] == '0) &&
                     (rsp_tdata[RSP_PULSE_LSB] ||
                      rsp_tdata[RSP_SPEED_LSB +: SPEED_W] == '0))
      else $error("position or speed reported when not valid");

endmodule

bind radar_target_emulator rte_checker u_rte_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
